@@ sv/quaternion_to_euler_macros.svh @@
// ---------------------------------------------------------------------------
// quaternion_to_euler_macros
// assertion helpers shared by the converter rtl
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH

// same-cycle implication
`define QTE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/qte_pkg.sv @@
// ---------------------------------------------------------------------------
// qte_pkg
// types, constants and tables of the quaternion to euler converter
// ---------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int IN_FRAC_BITS     = 14;
  localparam int CW               = 36;
  localparam int AW               = 34;
  localparam int NW               = 31;
  localparam int DW               = 33;
  localparam int RW               = 62;
  localparam int DIV_CELLS        = NW;
  localparam int SQRT_CELLS       = NW;

  localparam logic signed [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1} << (2 * IN_FRAC_BITS);
  localparam logic signed [AW-1:0] HALF_TURN   = AW'(64'sd2147483648);
  localparam logic        [31:0]   PI_Q29      = 32'd1686629713;
  localparam logic        [14:0]   ANGLE_LIMIT = 15'd25736;
  localparam logic signed [15:0]   PITCH_LOCK  = 16'sd12868;
  localparam logic signed [25:0]   LOCK_SCALE  = 26'sd20000000;
  localparam logic signed [24:0]   LOCK_BOUND  = 25'sd9999998;

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_POS  = 2'd1,
    LOCK_NEG  = 2'd2
  } lock_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    lock_t              lock_case;
  } euler_t;

  typedef struct packed {
    logic               zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
  } cord_t;

  typedef struct packed {
    logic [DW-1:0] norm;
    logic [DW:0]   rem;
    logic [NW-1:0] quo;
    logic          neg;
    logic          nz;
  } div_t;

  typedef struct packed {
    logic [RW-1:0]        v;
    logic [RW-1:0]        res;
    logic signed [NW:0]   s;
  } sqr_t;

  function automatic logic [31:0] atan_turn(input int i);
    case (i)
      0:       return 32'd536870912;
      1:       return 32'd316933406;
      2:       return 32'd167458907;
      3:       return 32'd85004756;
      4:       return 32'd42667331;
      5:       return 32'd21354465;
      6:       return 32'd10679838;
      7:       return 32'd5340245;
      8:       return 32'd2670163;
      9:       return 32'd1335087;
      10:      return 32'd667544;
      11:      return 32'd333772;
      12:      return 32'd166886;
      13:      return 32'd83443;
      14:      return 32'd41722;
      15:      return 32'd20861;
      16:      return 32'd10430;
      17:      return 32'd5215;
      18:      return 32'd2608;
      19:      return 32'd1304;
      20:      return 32'd652;
      21:      return 32'd326;
      22:      return 32'd163;
      23:      return 32'd81;
      default: return 32'd0;
    endcase
  endfunction

  // half-turn prerotation for a vector in the left half plane
  function automatic cord_t cord_pre(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y);
    cord_t c;
    c.zero = (x == '0) && (y == '0);
    c.x    = x;
    c.y    = y;
    c.ang  = '0;
    if (x < 0) begin
      c.ang = (y >= 0) ? HALF_TURN : -HALF_TURN;
      c.x   = -x;
      c.y   = -y;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/qte_div_cell.sv @@
// ---------------------------------------------------------------------------
// qte_div_cell
// one restoring division step, one quotient bit per cycle while en is high
// ---------------------------------------------------------------------------
`default_nettype none

module qte_div_cell (
  input  logic          clk,
  input  logic          en,
  input  qte_pkg::div_t d,
  output qte_pkg::div_t q
);
  import qte_pkg::*;

  logic          ge;
  logic [DW:0]   r1;
  div_t          nxt;

  always_comb begin
    ge      = d.rem >= {1'b0, d.norm};
    r1      = ge ? (d.rem - {1'b0, d.norm}) : d.rem;
    nxt     = d;
    nxt.rem = {r1[DW-1:0], 1'b0};
    nxt.quo = {d.quo[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/qte_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// qte_sqrt_cell
// one digit-by-digit square root step, one root bit per cycle while en is high
// ---------------------------------------------------------------------------
`default_nettype none

module qte_sqrt_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  qte_pkg::sqr_t d,
  output qte_pkg::sqr_t q
);
  import qte_pkg::*;

  localparam logic [RW-1:0] BIT = RW'(1) << SHIFT;

  logic [RW-1:0] trial;
  sqr_t          nxt;

  always_comb begin
    trial = d.res + BIT;
    nxt   = d;
    if (d.v >= trial) begin
      nxt.v   = d.v - trial;
      nxt.res = (d.res >> 1) + BIT;
    end else begin
      nxt.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/qte_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// qte_cordic_cell
// one vectoring cordic micro-rotation
// ---------------------------------------------------------------------------
`default_nettype none

module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  qte_pkg::cord_t d,
  output qte_pkg::cord_t q
);
  import qte_pkg::*;

  localparam logic signed [AW-1:0] ATAN = AW'(atan_turn(STEP));

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  cord_t                nxt;

  always_comb begin
    dx  = d.y >>> STEP;
    dy  = d.x >>> STEP;
    nxt = d;
    if (!d.y[CW-1]) begin
      nxt.x   = d.x + dx;
      nxt.y   = d.y - dy;
      nxt.ang = d.ang + ATAN;
    end else begin
      nxt.x   = d.x - dx;
      nxt.y   = d.y + dy;
      nxt.ang = d.ang - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/qte_angle.sv @@
// ---------------------------------------------------------------------------
// qte_angle
// binary angle to q3.13 radians, three register stages
// ---------------------------------------------------------------------------
`default_nettype none

module qte_angle (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [qte_pkg::AW-1:0]  t,
  output logic signed [15:0]             q
);
  import qte_pkg::*;

  localparam int PW = AW + 32;
  localparam logic [PW-1:0] RND = PW'(1) << 46;

  logic          neg_a;
  logic [AW-1:0] mag_a;
  logic          neg_b;
  logic [PW-1:0] prod_b;
  logic [PW-1:0] rnd;
  logic [PW-48:0] rmag;
  logic [14:0]   lim;
  logic signed [15:0] val;

  always_comb begin
    rnd  = prod_b + RND;
    rmag = rnd[PW-1:47];
    lim  = (rmag > (PW-47)'(ANGLE_LIMIT)) ? ANGLE_LIMIT : rmag[14:0];
    val  = signed'({1'b0, lim});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a  <= t[AW-1];
      mag_a  <= t[AW-1] ? AW'(-t) : AW'(t);
      neg_b  <= neg_a;
      prod_b <= {32'd0, mag_a} * {{AW{1'b0}}, PI_Q29};
      q      <= neg_b ? -val : val;
    end
  end

endmodule

`default_nettype wire

@@ sv/quaternion_to_euler.sv @@
// ---------------------------------------------------------------------------
// quaternion_to_euler
// quaternion (q1.14) to yaw, pitch, roll (q3.13 radians) with gimbal-lock flag
//
//   channel | ports                          | word
//   --------+--------------------------------+---------
//   in      | quat_valid, quat_stall, quat   | quat_t
//   out     | euler_valid, euler_stall, euler| euler_t
//
// one word per cycle sustained while no held result is stalled by euler_stall
// the path runs through the 31-cell divider, the 31-cell square root and the cordic row
// whole pipeline advances together; it halts only while a held result is stalled
// reset clears the valid bits only; no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none
`include "quaternion_to_euler_macros.svh"

module quaternion_to_euler #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            quat_valid,
  output logic            quat_stall,
  input  qte_pkg::quat_t  quat,
  output logic            euler_valid,
  input  logic            euler_stall,
  output qte_pkg::euler_t euler
);
  import qte_pkg::*;

  localparam int PRE_LAT  = 3;
  localparam int MID_LAT  = DIV_CELLS + 3 + SQRT_CELLS;
  localparam int LAT      = PRE_LAT + MID_LAT + 1 + CORDIC_STEPS + 3 + 1;
  localparam int LOCK_LEN = LAT - PRE_LAT - 1;
  localparam logic [NW-1:0] Q_MAX = NW'(1) << (NW - 1);
  localparam logic [RW-1:0] V_TOP = RW'(1) << (2 * (NW - 1));

  logic           en;
  logic [LAT-1:0] vld;

  // stage 1
  logic signed [15:0] s1_w, s1_y;
  logic signed [31:0] p_w2, p_x2, p_y2, p_z2, p_wx, p_yz, p_wz, p_xy, p_wy, p_xz;

  // stage 2
  logic signed [33:0]   norm_s;
  logic signed [32:0]   k_s;
  logic [DW-1:0]        s2_norm;
  logic signed [32:0]   s2_k;
  logic signed [57:0]   s2_lhs, s2_rhs;
  logic signed [CW-1:0] s2_yaw_x, s2_yaw_y, s2_roll_x, s2_roll_y;
  logic signed [15:0]   s2_w, s2_y;

  // stage 3
  logic signed [33:0]   k2;
  logic [33:0]          k2_mag;
  lock_t                s3_lock;
  logic signed [CW-1:0] s3_yaw_x, s3_yaw_y, s3_roll_x, s3_roll_y;

  div_t dv [0:DIV_CELLS];
  sqr_t sr [0:SQRT_CELLS];
  cord_t yc [0:CORDIC_STEPS];
  cord_t rc [0:CORDIC_STEPS];
  cord_t pc [0:CORDIC_STEPS];

  logic [NW-1:0]        qc;
  logic [NW-1:0]        sq_q;
  logic signed [NW:0]   sq_s;
  logic [RW-1:0]        m_sq;
  logic signed [NW:0]   m_s;

  logic signed [AW-1:0] yaw_t, roll_t, pit_t, yaw_nt, yaw_in;
  logic signed [AW-1:0] yaw_dly  [0:MID_LAT-1];
  logic signed [AW-1:0] roll_dly [0:MID_LAT-1];
  lock_t                lock_dly [0:LOCK_LEN-1];
  lock_t                lock_mid;
  lock_t                lock_end;
  logic signed [15:0]   yaw_q, pitch_q, roll_q;

  assign en          = !vld[LAT-1] || !euler_stall;
  assign quat_stall  = !en;
  assign euler_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], quat_valid};
    end
  end

  always_comb begin
    norm_s = 34'(p_w2) + 34'(p_x2) + 34'(p_y2) + 34'(p_z2);
    k_s    = 33'(p_wx) + 33'(p_yz);
    k2     = 34'(s2_k) <<< 1;
    k2_mag = k2[33] ? 34'(-k2) : 34'(k2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w <= quat.quat_w;
      s1_y <= quat.quat_y;
      p_w2 <= 32'(quat.quat_w) * 32'(quat.quat_w);
      p_x2 <= 32'(quat.quat_x) * 32'(quat.quat_x);
      p_y2 <= 32'(quat.quat_y) * 32'(quat.quat_y);
      p_z2 <= 32'(quat.quat_z) * 32'(quat.quat_z);
      p_wx <= 32'(quat.quat_w) * 32'(quat.quat_x);
      p_yz <= 32'(quat.quat_y) * 32'(quat.quat_z);
      p_wz <= 32'(quat.quat_w) * 32'(quat.quat_z);
      p_xy <= 32'(quat.quat_x) * 32'(quat.quat_y);
      p_wy <= 32'(quat.quat_w) * 32'(quat.quat_y);
      p_xz <= 32'(quat.quat_x) * 32'(quat.quat_z);

      s2_norm   <= norm_s[DW-1:0];
      s2_k      <= k_s;
      s2_lhs    <= 58'(k_s) * 58'(LOCK_SCALE);
      s2_rhs    <= 58'(norm_s) * 58'(LOCK_BOUND);
      s2_yaw_y  <= (CW'(p_wz) - CW'(p_xy)) <<< 1;
      s2_yaw_x  <= ONE - ((CW'(p_z2) + CW'(p_x2)) <<< 1);
      s2_roll_y <= (CW'(p_wy) - CW'(p_xz)) <<< 1;
      s2_roll_x <= ONE - ((CW'(p_y2) + CW'(p_x2)) <<< 1);
      s2_w      <= s1_w;
      s2_y      <= s1_y;

      if (s2_lhs > s2_rhs) begin
        s3_lock  <= LOCK_POS;
        s3_yaw_x <= CW'(s2_w);
        s3_yaw_y <= CW'(s2_y);
      end else if (s2_lhs < -s2_rhs) begin
        s3_lock  <= LOCK_NEG;
        s3_yaw_x <= CW'(s2_w);
        s3_yaw_y <= CW'(s2_y);
      end else begin
        s3_lock  <= LOCK_NONE;
        s3_yaw_x <= s2_yaw_x;
        s3_yaw_y <= s2_yaw_y;
      end
      s3_roll_x   <= s2_roll_x;
      s3_roll_y   <= s2_roll_y;
      dv[0].norm  <= s2_norm;
      dv[0].rem   <= {1'b0, k2_mag[DW-1:0]};
      dv[0].quo   <= '0;
      dv[0].neg   <= s2_k[32];
      dv[0].nz    <= s2_norm != '0;

      yc[0] <= cord_pre(s3_yaw_x, s3_yaw_y);
      rc[0] <= cord_pre(s3_roll_x, s3_roll_y);
    end
  end

  // arcsine argument: quotient row
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    qte_div_cell u_cell (.clk(clk), .en(en), .d(dv[i]), .q(dv[i+1]));
  end

  always_comb begin
    qc = (dv[DIV_CELLS].quo > Q_MAX) ? Q_MAX : dv[DIV_CELLS].quo;
    if (!dv[DIV_CELLS].nz) begin
      qc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_q     <= qc;
      sq_s     <= dv[DIV_CELLS].neg ? -signed'({1'b0, qc}) : signed'({1'b0, qc});
      m_sq     <= {{(RW-NW){1'b0}}, sq_q} * {{(RW-NW){1'b0}}, sq_q};
      m_s      <= sq_s;
      sr[0].v   <= V_TOP - m_sq;
      sr[0].res <= '0;
      sr[0].s   <= m_s;
      pc[0]     <= cord_pre(CW'(sr[SQRT_CELLS].res), CW'(sr[SQRT_CELLS].s));
    end
  end

  // cosine of pitch: square root row
  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    qte_sqrt_cell #(.SHIFT(2 * (SQRT_CELLS - 1 - j))) u_cell (
      .clk(clk), .en(en), .d(sr[j]), .q(sr[j+1])
    );
  end

  for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
    qte_cordic_cell #(.STEP(c)) u_yaw   (.clk(clk), .en(en), .d(yc[c]), .q(yc[c+1]));
    qte_cordic_cell #(.STEP(c)) u_roll  (.clk(clk), .en(en), .d(rc[c]), .q(rc[c+1]));
    qte_cordic_cell #(.STEP(c)) u_pitch (.clk(clk), .en(en), .d(pc[c]), .q(pc[c+1]));
  end

  always_comb begin
    yaw_t    = yc[CORDIC_STEPS].zero ? '0 : yc[CORDIC_STEPS].ang;
    roll_t   = rc[CORDIC_STEPS].zero ? '0 : rc[CORDIC_STEPS].ang;
    pit_t    = pc[CORDIC_STEPS].zero ? '0 : pc[CORDIC_STEPS].ang;
    lock_mid = lock_dly[MID_LAT + CORDIC_STEPS];
    lock_end = lock_dly[LOCK_LEN-1];
    yaw_nt   = -yaw_dly[MID_LAT-1];
    // doubled lock angle wraps within one turn
    case (lock_mid)
      LOCK_POS: yaw_in = AW'(signed'({yaw_dly[MID_LAT-1][30:0], 1'b0}));
      LOCK_NEG: yaw_in = AW'(signed'({yaw_nt[30:0], 1'b0}));
      default:  yaw_in = yaw_dly[MID_LAT-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_dly[0]  <= yaw_t;
      roll_dly[0] <= roll_t;
      for (int i = 1; i < MID_LAT; i++) begin
        yaw_dly[i]  <= yaw_dly[i-1];
        roll_dly[i] <= roll_dly[i-1];
      end
      lock_dly[0] <= s3_lock;
      for (int i = 1; i < LOCK_LEN; i++) begin
        lock_dly[i] <= lock_dly[i-1];
      end
    end
  end

  qte_angle u_yaw_ang   (.clk(clk), .en(en), .t(yaw_in),               .q(yaw_q));
  qte_angle u_pitch_ang (.clk(clk), .en(en), .t(pit_t),                .q(pitch_q));
  qte_angle u_roll_ang  (.clk(clk), .en(en), .t(roll_dly[MID_LAT-1]),  .q(roll_q));

  always_ff @(posedge clk) begin
    if (en) begin
      euler.yaw_angle <= yaw_q;
      euler.lock_case <= lock_end;
      case (lock_end)
        LOCK_POS: begin
          euler.pitch_angle <= PITCH_LOCK;
          euler.roll_angle  <= '0;
        end
        LOCK_NEG: begin
          euler.pitch_angle <= -PITCH_LOCK;
          euler.roll_angle  <= '0;
        end
        default: begin
          euler.pitch_angle <= pitch_q;
          euler.roll_angle  <= roll_q;
        end
      endcase
    end
  end

  `QTE_ASSERT_IMPL(a_hold, euler_valid && euler_stall, quat_stall, "word taken while held")
  `QTE_ASSERT_NEXT(a_take, quat_valid && !quat_stall, vld[0], "accepted word lost")
  `QTE_ASSERT_IMPL(a_roll, euler_valid && euler.lock_case != LOCK_NONE, euler.roll_angle == 16'sd0, "lock roll not zero")
  `QTE_ASSERT_IMPL(a_range, euler_valid, euler.yaw_angle <= 16'sd25736 && euler.yaw_angle >= -16'sd25736, "yaw out of range")

endmodule

`default_nettype wire
